>>> rtl/core/rkc_pkg.sv
`timescale 1ns / 1ps

package rkc_pkg;

    localparam int MaxNumbersDefault = 32;

    localparam int OpWidth    = 2;
    localparam int ValueWidth = 32;
    localparam int RankWidth  = 6;
    localparam int CharWidth  = 8;
    localparam int ShiftWidth = 5;
    localparam int ErrWidth   = 2;

    localparam logic [5:0] AlphaLen = 6'd26;
    localparam logic [CharWidth-1:0] LowerA = 8'h61;
    localparam logic [CharWidth-1:0] LowerZ = 8'h7A;

    // Modulo 26 of a signed 32-bit key: weigh each byte by 256^k mod 26, then
    // fold the sign bit (-2^32 is congruent to +4) and reduce the small sum
    localparam int SumWidth   = 14;
    localparam int QuotWidth  = 10;
    localparam int ProdWidth  = 30;
    localparam int RecipShift = 20;
    localparam logic [15:0] ModRecip = 16'd40330;   // ceil(2^20 / 26)
    localparam logic [4:0] Byte1Weight = 5'd22;
    localparam logic [4:0] Byte2Weight = 5'd16;
    localparam logic [4:0] Byte3Weight = 5'd14;
    localparam logic [4:0] SignFold    = 5'd4;

    typedef enum logic [OpWidth-1:0] {
        OP_LOAD    = 2'd0,
        OP_SELECT  = 2'd1,
        OP_ENCRYPT = 2'd2
    } op_t;

    typedef enum logic {
        KIND_KEY  = 1'b0,
        KIND_CHAR = 1'b1
    } kind_t;

    typedef enum logic [ErrWidth-1:0] {
        ERR_NONE     = 2'd0,
        ERR_RANK     = 2'd1,
        ERR_OVERFLOW = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_CAND,
        ST_LATCH_CAND,
        ST_SCAN,
        ST_CHECK,
        ST_MOD,
        ST_QUOT,
        ST_FINISH
    } state_t;

endpackage

>>> rtl/core/ranked_key_caesar_cipher_top.sv
`timescale 1ns / 1ps

// Channel   Dir   Transfer when          Payload
// s_        in    s_tvalid & s_tready    tuser: operation; tdata: number, rank, char
// m_        out   m_tvalid & m_tready    tuser: result kind; tdata: shift, char, error
//
// Load, encrypt and a select with an out-of-range rank finish in the cycle of
// the transfer; the result (if any) sits in the output register in the next cycle.
// A valid select walks the store: for each candidate tried, a read, a latch, a
// compare against each stored number and a rank check; then it folds the key's
// bytes, takes the reciprocal quotient, and takes the remainder mod 26 and
// finishes. Its length is set by the single store read port and the shared
// signed comparator.
// s_tready is low while a select is being worked.
// Reset (aresetn low, synchronous) empties the set, zeroes the shift and drops
// any pending result; the store itself is not cleared.
// A stalled output holds its result; a new item is taken in the cycle the old
// result leaves.

module ranked_key_caesar_cipher_top
    import rkc_pkg::*;
#(
    parameter int MAX_NUMBERS = MaxNumbersDefault
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] number_value, [37:32] rank, [45:38] char_in
    input  logic [1:0]  s_tuser,   // [1:0] operation

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [4:0] shift_out, [12:5] char_out, [14:13] error_code
    output logic        m_tuser    // [0] result_kind
);

    localparam int IW = $clog2(MAX_NUMBERS);
    localparam int CW = $clog2(MAX_NUMBERS + 1);
    localparam int KW = ((CW > RankWidth) ? CW : RankWidth) + 1;

    // Sequencer and set state
    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [ShiftWidth-1:0]  shift_reg, shift_next;
    logic                   closed_reg, closed_next;
    logic                   ovf_reg, ovf_next;

    // Select working registers
    logic [RankWidth-1:0]   rank_reg, rank_next;
    logic [IW-1:0]          i_reg, i_next;
    logic [IW-1:0]          j_reg, j_next;
    logic [ValueWidth-1:0]  cand_reg, cand_next;
    logic [CW-1:0]          less_reg, less_next;
    logic [CW-1:0]          equal_reg, equal_next;
    logic [SumWidth-1:0]    sum_reg, sum_next;
    logic [QuotWidth-1:0]   quot_reg, quot_next;

    // Output register
    logic                   m_valid_reg, m_valid_next;
    kind_t                  m_kind_reg, m_kind_next;
    logic [ShiftWidth-1:0]  m_shift_reg, m_shift_next;
    logic [CharWidth-1:0]   m_char_reg, m_char_next;
    err_t                   m_err_reg, m_err_next;

    // Store port
    logic                   ram_we;
    logic [IW-1:0]          ram_waddr;
    logic [IW-1:0]          ram_raddr;
    logic [ValueWidth-1:0]  ram_rdata;

    // Input fields
    op_t                    in_op;
    logic [ValueWidth-1:0]  in_value;
    logic [RankWidth-1:0]   in_rank;
    logic [CharWidth-1:0]   in_char;
    logic                   in_accept;

    // Scratch
    logic [CW-1:0]          base_count;
    logic                   base_ovf;
    logic [5:0]             rot;
    logic [ProdWidth-1:0]   prod;
    logic [SumWidth-1:0]    remv;
    logic [ShiftWidth-1:0]  fixed;

    assign in_op    = op_t'(s_tuser);
    assign in_value = s_tdata[31:0];
    assign in_rank  = s_tdata[37:32];
    assign in_char  = s_tdata[45:38];

    // Take a new item when idle and the output register is free or draining
    assign s_tready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign in_accept = s_tvalid && s_tready;

    rkc_ram #(
        .Width (ValueWidth),
        .Depth (MAX_NUMBERS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        shift_next   = shift_reg;
        closed_next  = closed_reg;
        ovf_next     = ovf_reg;
        rank_next    = rank_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        cand_next    = cand_reg;
        less_next    = less_reg;
        equal_next   = equal_reg;
        sum_next     = sum_reg;
        quot_next    = quot_reg;
        m_valid_next = m_valid_reg;
        m_kind_next  = m_kind_reg;
        m_shift_next = m_shift_reg;
        m_char_next  = m_char_reg;
        m_err_next   = m_err_reg;

        ram_we    = 1'b0;
        ram_raddr = i_reg;

        // A load after a select starts a fresh set
        base_count = closed_reg ? '0 : count_reg;
        base_ovf   = closed_reg ? 1'b0 : ovf_reg;
        ram_waddr  = base_count[IW-1:0];

        rot = 6'(in_char - LowerA) + 6'(shift_reg);
        if (rot >= AlphaLen) begin
            rot = rot - AlphaLen;
        end

        // Quotient by reciprocal multiplication, then the remainder
        prod  = ProdWidth'(sum_reg) * ProdWidth'(ModRecip);
        remv  = sum_reg - SumWidth'(quot_reg) * SumWidth'(AlphaLen);
        fixed = ShiftWidth'(remv);

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    case (in_op)
                        OP_LOAD: begin
                            closed_next = 1'b0;
                            ovf_next    = base_ovf;
                            count_next  = base_count;
                            if (base_count < CW'(MAX_NUMBERS)) begin
                                ram_we     = 1'b1;
                                count_next = base_count + CW'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_SELECT: begin
                            closed_next = 1'b1;
                            if (in_rank == '0 || KW'(in_rank) > KW'(count_reg)) begin
                                m_valid_next = 1'b1;
                                m_kind_next  = KIND_KEY;
                                m_shift_next = '0;
                                m_char_next  = '0;
                                m_err_next   = ERR_RANK;
                            end else begin
                                rank_next  = in_rank;
                                i_next     = '0;
                                state_next = ST_READ_CAND;
                            end
                        end
                        OP_ENCRYPT: begin
                            m_valid_next = 1'b1;
                            m_kind_next  = KIND_CHAR;
                            m_shift_next = shift_reg;
                            m_err_next   = ERR_NONE;
                            if (in_char >= LowerA && in_char <= LowerZ) begin
                                m_char_next = LowerA + CharWidth'(rot);
                            end else begin
                                m_char_next = in_char;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ_CAND: begin
                ram_raddr  = i_reg;
                state_next = ST_LATCH_CAND;
            end
            ST_LATCH_CAND: begin
                cand_next  = ram_rdata;
                ram_raddr  = '0;
                j_next     = '0;
                less_next  = '0;
                equal_next = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                // Shared signed comparator: stored entry against the candidate
                if ($signed(ram_rdata) < $signed(cand_reg)) begin
                    less_next = less_reg + CW'(1);
                end else if (ram_rdata == cand_reg) begin
                    equal_next = equal_reg + CW'(1);
                end
                ram_raddr = j_reg + IW'(1);
                j_next    = j_reg + IW'(1);
                if (CW'(j_reg) == count_reg - CW'(1)) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (KW'(less_reg) < KW'(rank_reg) &&
                    KW'(less_reg) + KW'(equal_reg) >= KW'(rank_reg)) begin
                    state_next = ST_MOD;
                end else begin
                    i_next     = i_reg + IW'(1);
                    state_next = ST_READ_CAND;
                end
            end
            ST_MOD: begin
                // Fold the bytes by their weights mod 26; add 4 for the sign bit
                sum_next = SumWidth'(cand_reg[7:0])
                         + SumWidth'(cand_reg[15:8]) * SumWidth'(Byte1Weight)
                         + SumWidth'(cand_reg[23:16]) * SumWidth'(Byte2Weight)
                         + SumWidth'(cand_reg[31:24]) * SumWidth'(Byte3Weight)
                         + (cand_reg[ValueWidth-1] ? SumWidth'(SignFold) : '0);
                state_next = ST_QUOT;
            end
            ST_QUOT: begin
                quot_next  = prod[RecipShift +: QuotWidth];
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                shift_next   = fixed;
                m_valid_next = 1'b1;
                m_kind_next  = KIND_KEY;
                m_shift_next = fixed;
                m_char_next  = '0;
                m_err_next   = ovf_reg ? ERR_OVERFLOW : ERR_NONE;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            shift_reg   <= '0;
            closed_reg  <= 1'b0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            shift_reg   <= shift_next;
            closed_reg  <= closed_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge aclk) begin
        rank_reg    <= rank_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        cand_reg    <= cand_next;
        less_reg    <= less_next;
        equal_reg   <= equal_next;
        sum_reg     <= sum_next;
        quot_reg    <= quot_next;
        m_kind_reg  <= m_kind_next;
        m_shift_reg <= m_shift_next;
        m_char_reg  <= m_char_next;
        m_err_reg   <= m_err_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {1'b0, m_err_reg, m_char_reg, m_shift_reg};

`ifndef SYNTHESIS
    // The store never holds more than its capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_NUMBERS))
        else $error("stored count beyond capacity");

    // The active shift is always a valid rotation
    a_shift_range: assert property (@(posedge aclk) disable iff (!aresetn)
        shift_reg < ShiftWidth'(AlphaLen))
        else $error("shift out of range");

    // No result is pending while a select is being worked
    a_busy_no_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !m_valid_reg)
        else $error("result pending during select walk");

    // The scan stays inside the filled part of the store
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (CW'(j_reg) < count_reg))
        else $error("scan index past stored count");

    // A successful key report carries the shift now in force
    a_key_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg == KIND_KEY && m_err_reg != ERR_RANK)
            |-> (m_shift_reg == shift_reg))
        else $error("key report disagrees with active shift");
`endif

endmodule

>>> rtl/core/rkc_ram.sv
`timescale 1ns / 1ps

module rkc_ram #(
    parameter int Width = 32,
    parameter int Depth = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem_reg [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> tb/ranked_key_caesar_cipher_top_tb.sv
`timescale 1ns / 1ps

module ranked_key_caesar_cipher_top_tb;
    import rkc_pkg::*;

    localparam int STORE_DEPTH     = MaxNumbersDefault;
    localparam int RANDOM_ITEMS    = 1800;
    localparam int HOLD_OFF_CYCLES = 400;
    // allow for the worst select and a hold-off, many times over
    localparam int WATCHDOG_LIMIT  = 10000;
    localparam int DRAIN_CYCLES    = 60;
    localparam logic [OpWidth-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [OpWidth-1:0]    op;
        logic [ValueWidth-1:0] number;
        logic [RankWidth-1:0]  rank;
        logic [CharWidth-1:0]  ch;
        int                    phase;
        bit                    hold_rx;      // receiver holds off once this is taken
        bit                    drain_first;  // sender waits for all results first
    } cipher_item_t;

    typedef struct {
        kind_t                 kind;
        logic [ShiftWidth-1:0] shift;
        logic [CharWidth-1:0]  ch;
        err_t                  err;
    } cipher_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // [31:0] number_value, [37:32] rank, [45:38] char_in
    logic [1:0]  s_tuser  = '0;   // [1:0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [4:0] shift_out, [12:5] char_out, [14:13] error_code
    logic        m_tuser;         // [0] result_kind

    ranked_key_caesar_cipher_top #(
        .MAX_NUMBERS(STORE_DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #2 aclk = ~aclk;

    // Stimulus and scoreboard
    cipher_item_t   pending_items[$];
    cipher_result_t expected_results[$];
    cipher_item_t   offered_item;
    int issued_count   = 0;
    int accept_count   = 0;
    int mismatch_count = 0;
    int hold_requests  = 0;
    int rx_phase       = 0;

    // Predicted block state
    int                    held_numbers[STORE_DEPTH];
    int                    held_count = 0;
    logic [ShiftWidth-1:0] cur_shift  = '0;
    bit                    set_closed = 1'b0;
    bit                    overflowed = 1'b0;

    // Generator bookkeeping: track the set size so that ranks can be aimed
    int items_made  = 0;
    int gen_phase   = 0;
    int gen_held    = 0;
    bit gen_closed  = 1'b0;
    bit drain_next  = 1'b0;
    bit hold_next   = 1'b0;
    bit hold_armed  = 1'b0;

    function automatic int sender_idle_pct(input int phase);
        case (phase)
            1: return 54;
            3: return 31;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct(input int phase);
        case (phase)
            2: return 54;
            3: return 31;
            default: return 0;
        endcase
    endfunction

    task automatic add_item(input logic [OpWidth-1:0] op, input logic [ValueWidth-1:0] number,
                            input logic [RankWidth-1:0] rank, input logic [CharWidth-1:0] ch);
        cipher_item_t it;
        it.op          = op;
        it.number      = number;
        it.rank        = rank;
        it.ch          = ch;
        it.phase       = gen_phase;
        it.hold_rx     = hold_next;
        it.drain_first = drain_next;
        hold_next      = 1'b0;
        drain_next     = 1'b0;
        pending_items.push_back(it);
        if (op == OP_LOAD) begin
            if (gen_closed) begin
                gen_held   = 0;
                gen_closed = 1'b0;
            end
            if (gen_held < STORE_DEPTH) gen_held++;
        end else if (op == OP_SELECT) begin
            gen_closed = 1'b1;
        end
        if (op != OP_UNUSED) items_made++;
    endtask

    function automatic logic [ValueWidth-1:0] pick_number(input logic [ValueWidth-1:0] last);
        int roll;
        roll = $urandom_range(99);
        if (roll < 25) return $urandom;
        if (roll < 50) return ValueWidth'($urandom_range(60)) - 32'd30;
        if (roll < 65) return last;
        if (roll < 75) begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return ValueWidth'($urandom_range(1000)) - 32'd500;
    endfunction

    function automatic logic [RankWidth-1:0] pick_rank(input int held);
        int roll;
        roll = $urandom_range(99);
        if (roll < 70 && held > 0) return RankWidth'($urandom_range(1, held));
        if (roll < 80) return '0;
        if (roll < 90) return RankWidth'($urandom_range(held + 1, 63));
        return RankWidth'($urandom);
    endfunction

    function automatic logic [CharWidth-1:0] pick_char();
        if ($urandom_range(99) < 60) return CharWidth'($urandom_range(int'(LowerA), int'(LowerZ)));
        return CharWidth'($urandom);
    endfunction

    // Arm a receiver hold-off on the first encrypt of a run once per phase, and now and then
    task automatic add_encrypt_run(input int count);
        for (int j = 0; j < count; j++) begin
            if (j == 0 && (hold_armed || $urandom_range(79) == 0)) begin
                hold_next  = 1'b1;
                hold_armed = 1'b0;
            end
            add_item(OP_ENCRYPT, $urandom, RankWidth'($urandom), pick_char());
        end
    endtask

    task automatic build_stimulus();
        int base;
        int roll;
        int set_size;
        int phase_now;
        logic [ValueWidth-1:0] last;

        // Directed: shift at reset, empty set, extremes and duplicates, rank errors
        add_item(OP_ENCRYPT, $urandom, '0, LowerA);
        add_item(OP_SELECT, $urandom, 6'd1, CharWidth'($urandom));
        add_item(OP_LOAD, 32'h8000_0000, 6'd63, 8'hFF);
        add_item(OP_LOAD, 32'h7FFF_FFFF, 6'd0, 8'h00);
        add_item(OP_LOAD, 32'h0000_0000, 6'd21, 8'hAA);
        add_item(OP_LOAD, 32'hFFFF_FFFF, 6'd42, 8'h55);
        add_item(OP_LOAD, 32'hFFFF_FFFF, 6'd1, 8'h61);
        add_item(OP_LOAD, 32'd27, 6'd2, 8'h7A);
        add_item(OP_SELECT, $urandom, 6'd0, CharWidth'($urandom));
        add_item(OP_SELECT, $urandom, 6'd7, CharWidth'($urandom));
        add_item(OP_SELECT, $urandom, 6'd63, CharWidth'($urandom));
        add_item(OP_SELECT, $urandom, 6'd1, CharWidth'($urandom));
        add_item(OP_ENCRYPT, $urandom, '0, LowerZ);
        add_item(OP_SELECT, $urandom, 6'd3, CharWidth'($urandom));
        add_item(OP_ENCRYPT, $urandom, '0, LowerA);
        add_item(OP_ENCRYPT, $urandom, '0, 8'h6D);
        add_item(OP_ENCRYPT, $urandom, '0, 8'h41);
        add_item(OP_ENCRYPT, $urandom, '0, 8'h00);
        add_item(OP_ENCRYPT, $urandom, '0, 8'hFF);
        add_item(OP_ENCRYPT, $urandom, '0, 8'h60);
        add_item(OP_ENCRYPT, $urandom, '0, 8'h7B);
        add_item(OP_SELECT, $urandom, 6'd6, CharWidth'($urandom));
        add_item(OP_UNUSED, $urandom, RankWidth'($urandom), CharWidth'($urandom));
        add_item(OP_LOAD, 32'd5, '0, '0);
        add_item(OP_SELECT, $urandom, 6'd2, CharWidth'($urandom));
        add_item(OP_ENCRYPT, $urandom, '0, 8'h62);

        base      = items_made;
        gen_phase = -1;
        last      = '0;
        while (items_made < base + RANDOM_ITEMS) begin
            phase_now = (items_made - base) * 4 / RANDOM_ITEMS;
            if (phase_now != gen_phase) begin
                gen_phase  = phase_now;
                drain_next = 1'b1;
                hold_armed = 1'b1;
            end
            roll = $urandom_range(99);
            if (roll < 70) begin
                // Well-formed: fill a set, pick a key, encrypt some text
                roll = $urandom_range(99);
                if (roll < 85)      set_size = $urandom_range(1, 8);
                else if (roll < 95) set_size = $urandom_range(9, 31);
                else                set_size = $urandom_range(32, 40);
                for (int i = 0; i < set_size; i++) begin
                    last = pick_number(last);
                    add_item(OP_LOAD, last, RankWidth'($urandom), CharWidth'($urandom));
                end
                repeat ($urandom_range(1, 2))
                    add_item(OP_SELECT, $urandom, pick_rank(gen_held), CharWidth'($urandom));
                add_encrypt_run($urandom_range(0, 12));
            end else if (roll < 84) begin
                add_encrypt_run($urandom_range(1, 15));
            end else if (roll < 94) begin
                // Broken: repeated selects on a closed set, or loads left open
                if ($urandom_range(1)) begin
                    repeat ($urandom_range(1, 3))
                        add_item(OP_SELECT, $urandom, pick_rank(gen_held), CharWidth'($urandom));
                end else begin
                    repeat ($urandom_range(1, 5)) begin
                        last = pick_number(last);
                        add_item(OP_LOAD, last, RankWidth'($urandom), CharWidth'($urandom));
                    end
                    add_encrypt_run($urandom_range(1, 4));
                end
            end else begin
                repeat ($urandom_range(1, 3))
                    add_item(OP_UNUSED, $urandom, RankWidth'($urandom), CharWidth'($urandom));
            end
        end
    endtask

    // Value at one-based position k of the held numbers in ascending order
    function automatic int ranked_number(input int k);
        int less;
        int equal;
        for (int i = 0; i < held_count; i++) begin
            less  = 0;
            equal = 0;
            for (int j = 0; j < held_count; j++) begin
                if (held_numbers[j] < held_numbers[i]) less++;
                else if (held_numbers[j] == held_numbers[i]) equal++;
            end
            if (less < k && k <= less + equal) return held_numbers[i];
        end
        return 0;
    endfunction

    // True modulo, so negative numbers land in 0..25
    function automatic logic [ShiftWidth-1:0] wrap_shift(input int v);
        int r;
        r = v % int'(AlphaLen);
        if (r < 0) r += int'(AlphaLen);
        return ShiftWidth'(r);
    endfunction

    task automatic predict_cipher_result(input cipher_item_t it);
        cipher_result_t res;
        int c;
        case (it.op)
            OP_LOAD: begin
                // the first load after a select opens a new set
                if (set_closed) begin
                    held_count = 0;
                    overflowed = 1'b0;
                    set_closed = 1'b0;
                end
                if (held_count < STORE_DEPTH) begin
                    held_numbers[held_count] = int'(signed'(it.number));
                    held_count++;
                end else begin
                    overflowed = 1'b1;
                end
            end
            OP_SELECT: begin
                set_closed = 1'b1;
                res.kind   = KIND_KEY;
                res.ch     = '0;
                if (it.rank == 0 || int'(it.rank) > held_count) begin
                    res.shift = '0;
                    res.err   = ERR_RANK;
                end else begin
                    cur_shift = wrap_shift(ranked_number(int'(it.rank)));
                    res.shift = cur_shift;
                    res.err   = overflowed ? ERR_OVERFLOW : ERR_NONE;
                end
                expected_results.push_back(res);
            end
            OP_ENCRYPT: begin
                c = int'(it.ch);
                if (it.ch >= LowerA && it.ch <= LowerZ)
                    c = (c - int'(LowerA) + int'(cur_shift)) % int'(AlphaLen) + int'(LowerA);
                res.kind  = KIND_CHAR;
                res.shift = cur_shift;
                res.ch    = CharWidth'(c);
                res.err   = ERR_NONE;
                expected_results.push_back(res);
            end
            default: begin
                // unused code: no result, no state change
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    endtask

    // Sender: present the next item at the falling edge; hold it until its transfer
    always @(negedge aclk) begin : sender
        cipher_item_t next_item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (issued_count == accept_count) begin
            if (pending_items.size() != 0
                    && !(pending_items[0].drain_first && expected_results.size() != 0)
                    && $urandom_range(99) >= sender_idle_pct(pending_items[0].phase)) begin
                next_item    = pending_items.pop_front();
                offered_item = next_item;
                issued_count++;
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, next_item.ch, next_item.rank, next_item.number};
                s_tuser  <= next_item.op;
            end else begin
                // idle: scramble the payload so that only tvalid qualifies it
                s_tvalid <= 1'b0;
                s_tdata  <= 48'({$urandom, $urandom});
                s_tuser  <= 2'($urandom);
            end
        end
    end

    // Receiver: random stalls by phase, plus a long hold-off on request
    int hold_grant = 0;
    int hold_left  = 0;

    always @(negedge aclk) begin
        if (hold_grant != hold_requests) begin
            hold_grant = hold_requests;
            hold_left  = HOLD_OFF_CYCLES;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_stall_pct(rx_phase));
        end
    end

    // Monitor: predict on each input transfer, check each output transfer
    always @(posedge aclk) begin : monitor
        cipher_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_cipher_result(offered_item);
                accept_count++;
                rx_phase = offered_item.phase;
                if (offered_item.hold_rx) hold_requests++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing outstanding", int'(m_tdata), -1);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.kind)
                        report_mismatch("result_kind", int'(m_tuser), int'(want.kind));
                    if (m_tdata[4:0] !== want.shift)
                        report_mismatch("shift_out", int'(m_tdata[4:0]), int'(want.shift));
                    if (m_tdata[12:5] !== want.ch)
                        report_mismatch("char_out", int'(m_tdata[12:5]), int'(want.ch));
                    if (m_tdata[14:13] !== want.err)
                        report_mismatch("error_code", int'(m_tdata[14:13]), int'(want.err));
                end
            end
        end
    end

    // Watchdog: end the run if no transfer happens for too long
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        build_stimulus();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // wait for every item to transfer and every result to arrive
        while (!(pending_items.size() == 0 && issued_count == accept_count
                 && expected_results.size() == 0))
            @(posedge aclk);
        // allow time for any stray result to show up
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/rkc_pkg.sv
rtl/core/rkc_ram.sv
rtl/core/ranked_key_caesar_cipher_top.sv
tb/ranked_key_caesar_cipher_top_tb.sv
